// ===== hw/rtl/fng_pkg.sv =====
// Shared constants, widths and types for the four nearest grid points search.
package fng_pkg;

  localparam int unsigned NEIGHBORS = 4;
  localparam int unsigned GRID_ROWS = 1024;
  localparam int unsigned GRID_COLS = 1024;

  localparam int unsigned POS_W   = 28;
  localparam int unsigned IDX_W   = 10;
  localparam int unsigned RAD_W   = 27;
  localparam int unsigned BOUND_W = 2 * RAD_W;
  localparam int unsigned SQ_W    = 2 * POS_W;
  localparam int unsigned DIST_W  = 58;
  localparam int unsigned RANK_W  = 2;

  localparam logic [RAD_W-1:0] RADIUS_RESET = 27'd1600000;

  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [DIST_W-1:0] dist_t;
  typedef logic [RANK_W-1:0] rank_t;

  // One measured point on its way to the sorted list.
  typedef struct packed {
    logic  last;
    logic  in_grid;
    idx_t  row;
    idx_t  col;
    dist_t dist_sq;
  } point_t;

  // Ranked list captured at the end of a search.
  typedef struct packed {
    logic                  found;
    idx_t  [NEIGHBORS-1:0] row;
    idx_t  [NEIGHBORS-1:0] col;
    dist_t [NEIGHBORS-1:0] dist_sq;
  } snap_t;

endpackage

// ===== hw/rtl/fng_dist.sv =====
// Squared distance pipeline: input register, absolute differences, squares, sum.
module fng_dist (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        adv,
  input  logic                        in_valid,
  input  logic signed [fng_pkg::POS_W-1:0] query_east,
  input  logic signed [fng_pkg::POS_W-1:0] query_north,
  input  logic signed [fng_pkg::POS_W-1:0] point_east,
  input  logic signed [fng_pkg::POS_W-1:0] point_north,
  input  fng_pkg::idx_t               point_row,
  input  fng_pkg::idx_t               point_col,
  input  logic                        last_point,
  output logic                        pt_valid,
  output fng_pkg::point_t             pt
);

  // stage 1: captured request
  logic                             v1;
  logic signed [fng_pkg::POS_W-1:0] qe1, qn1, pe1, pn1;
  fng_pkg::idx_t                    row1, col1;
  logic                             last1;

  // stage 2: magnitudes
  logic                      v2;
  logic [fng_pkg::POS_W-1:0] abs_e2, abs_n2;
  fng_pkg::idx_t             row2, col2;
  logic                      last2, grid2;

  // stage 3: squares
  logic                     v3;
  logic [fng_pkg::SQ_W-1:0] sq_e3, sq_n3;
  fng_pkg::idx_t            row3, col3;
  logic                     last3, grid3;

  logic signed [fng_pkg::POS_W:0] de, dn;
  logic [fng_pkg::POS_W:0]        de_mag, dn_mag;
  logic                           grid_next;
  logic [fng_pkg::SQ_W:0]         sum_next;

  always_comb begin
    de = $signed({pe1[fng_pkg::POS_W-1], pe1}) - $signed({qe1[fng_pkg::POS_W-1], qe1});
    dn = $signed({pn1[fng_pkg::POS_W-1], pn1}) - $signed({qn1[fng_pkg::POS_W-1], qn1});
    de_mag = de[fng_pkg::POS_W] ? (fng_pkg::POS_W + 1)'(-de) : (fng_pkg::POS_W + 1)'(de);
    dn_mag = dn[fng_pkg::POS_W] ? (fng_pkg::POS_W + 1)'(-dn) : (fng_pkg::POS_W + 1)'(dn);
    grid_next = (32'(row1) < fng_pkg::GRID_ROWS) && (32'(col1) < fng_pkg::GRID_COLS);
    sum_next = (fng_pkg::SQ_W + 1)'(sq_e3) + (fng_pkg::SQ_W + 1)'(sq_n3);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1       <= 1'b0;
      v2       <= 1'b0;
      v3       <= 1'b0;
      pt_valid <= 1'b0;
    end else if (adv) begin
      v1       <= in_valid;
      v2       <= v1;
      v3       <= v2;
      pt_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      qe1   <= query_east;
      qn1   <= query_north;
      pe1   <= point_east;
      pn1   <= point_north;
      row1  <= point_row;
      col1  <= point_col;
      last1 <= last_point;

      abs_e2 <= de_mag[fng_pkg::POS_W-1:0];
      abs_n2 <= dn_mag[fng_pkg::POS_W-1:0];
      row2   <= row1;
      col2   <= col1;
      last2  <= last1;
      grid2  <= grid_next;

      sq_e3 <= fng_pkg::SQ_W'(abs_e2) * fng_pkg::SQ_W'(abs_e2);
      sq_n3 <= fng_pkg::SQ_W'(abs_n2) * fng_pkg::SQ_W'(abs_n2);
      row3  <= row2;
      col3  <= col2;
      last3 <= last2;
      grid3 <= grid2;

      pt.dist_sq <= fng_pkg::DIST_W'(sum_next);
      pt.row     <= row3;
      pt.col     <= col3;
      pt.last    <= last3;
      pt.in_grid <= grid3;
    end
  end

endmodule

// ===== hw/rtl/fng_list.sv =====
// Sorted insertion list of the nearest points, with the radius bound.
module fng_list (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        fire,
  input  fng_pkg::point_t             pt,
  input  logic [fng_pkg::RAD_W-1:0]   radius,
  output logic                        snap_load,
  output fng_pkg::snap_t              snap
);

  localparam int unsigned N = fng_pkg::NEIGHBORS;

  fng_pkg::dist_t bound;
  fng_pkg::dist_t slot_dist_sq [N];
  fng_pkg::idx_t  slot_row [N];
  fng_pkg::idx_t  slot_col [N];
  logic [N-1:0]   slot_valid;

  fng_pkg::dist_t thr [N];
  logic [N-1:0]   lt;
  logic [N-1:0]   ahead;
  fng_pkg::dist_t dist_next [N];
  fng_pkg::idx_t  row_next [N];
  fng_pkg::idx_t  col_next [N];
  logic [N-1:0]   valid_next;
  logic [fng_pkg::BOUND_W-1:0] bound_prod;
  logic           sorted_ok;

  assign bound_prod = fng_pkg::BOUND_W'(radius) * fng_pkg::BOUND_W'(radius);

  // insert ahead of the first slot the point beats strictly; shift the rest down
  always_comb begin
    for (int k = 0; k < N; k++) begin
      thr[k] = slot_valid[k] ? slot_dist_sq[k] : bound;
      lt[k]  = pt.in_grid && (pt.dist_sq < thr[k]);
    end
    ahead[0] = 1'b0;
    for (int k = 1; k < N; k++) begin
      ahead[k] = ahead[k-1] | lt[k-1];
    end
    for (int k = 0; k < N; k++) begin
      if (ahead[k] && k > 0) begin
        dist_next[k]  = slot_dist_sq[k-1];
        row_next[k]   = slot_row[k-1];
        col_next[k]   = slot_col[k-1];
        valid_next[k] = slot_valid[k-1];
      end else if (lt[k]) begin
        dist_next[k]  = pt.dist_sq;
        row_next[k]   = pt.row;
        col_next[k]   = pt.col;
        valid_next[k] = 1'b1;
      end else begin
        dist_next[k]  = slot_dist_sq[k];
        row_next[k]   = slot_row[k];
        col_next[k]   = slot_col[k];
        valid_next[k] = slot_valid[k];
      end
    end
  end

  always_comb begin
    snap.found = &valid_next;
    for (int k = 0; k < N; k++) begin
      snap.row[k]     = snap.found ? row_next[k] : '0;
      snap.col[k]     = snap.found ? col_next[k] : '0;
      snap.dist_sq[k] = valid_next[k] ? dist_next[k] : bound;
    end
  end

  assign snap_load = fire && pt.last;

  always_ff @(posedge clk) begin
    bound <= fng_pkg::DIST_W'(bound_prod);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
    end else if (fire) begin
      // the last point of a search empties the list
      slot_valid <= pt.last ? '0 : valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      for (int k = 0; k < N; k++) begin
        slot_dist_sq[k] <= dist_next[k];
        slot_row[k]     <= row_next[k];
        slot_col[k]     <= col_next[k];
      end
    end
  end

  always_comb begin
    sorted_ok = 1'b1;
    for (int k = 1; k < N; k++) begin
      if (slot_valid[k] && (slot_dist_sq[k] < slot_dist_sq[k-1])) begin
        sorted_ok = 1'b0;
      end
    end
  end

  a_valid_prefix: assert property (@(posedge clk) disable iff (rst)
    (slot_valid[N-1:1] & ~slot_valid[N-2:0]) == '0)
    else $error("slot valid bits are not a prefix");

  a_sorted: assert property (@(posedge clk) disable iff (rst)
    sorted_ok)
    else $error("slot list out of order");

  a_cleared: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && $past(snap_load) |-> slot_valid == '0)
    else $error("list not emptied after a search ended");

endmodule

// ===== hw/rtl/fng_out.sv =====
// Result bank: holds one ranked list and hands it out one rank per request.
module fng_out (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   load,
  input  fng_pkg::snap_t         snap,
  output logic                   load_ready,
  output logic                   out_valid,
  input  logic                   out_stall,
  output fng_pkg::rank_t         rank,
  output fng_pkg::idx_t          near_row,
  output fng_pkg::idx_t          near_col,
  output fng_pkg::dist_t         near_dist_sq,
  output logic                   found,
  output logic                   last_result
);

  localparam int unsigned N = fng_pkg::NEIGHBORS;

  logic           busy;
  fng_pkg::rank_t rank_q;
  fng_pkg::idx_t  bank_row [N];
  fng_pkg::idx_t  bank_col [N];
  fng_pkg::dist_t bank_dist [N];
  logic           bank_found;
  logic           take;
  logic           at_end;

  assign take       = busy && !out_stall;
  assign at_end     = rank_q == fng_pkg::RANK_W'(N - 1);
  assign load_ready = !busy || (take && at_end);

  assign out_valid    = busy;
  assign rank         = rank_q;
  assign near_row     = bank_row[0];
  assign near_col     = bank_col[0];
  assign near_dist_sq = bank_dist[0];
  assign found        = bank_found;
  assign last_result  = at_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      rank_q <= '0;
    end else if (load) begin
      busy   <= 1'b1;
      rank_q <= '0;
    end else if (take) begin
      rank_q <= rank_q + 1'b1;
      if (at_end) begin
        busy <= 1'b0;
      end
    end
  end

  // advance the bank so the current rank always sits in entry 0
  always_ff @(posedge clk) begin
    if (load) begin
      bank_found <= snap.found;
      for (int k = 0; k < N; k++) begin
        bank_row[k]  <= snap.row[k];
        bank_col[k]  <= snap.col[k];
        bank_dist[k] <= snap.dist_sq[k];
      end
    end else if (take) begin
      for (int k = 0; k < N - 1; k++) begin
        bank_row[k]  <= bank_row[k+1];
        bank_col[k]  <= bank_col[k+1];
        bank_dist[k] <= bank_dist[k+1];
      end
    end
  end

  a_load_ok: assert property (@(posedge clk) disable iff (rst)
    load |-> load_ready)
    else $error("list loaded over results not yet taken");

  a_busy_holds: assert property (@(posedge clk) disable iff (rst)
    busy && !at_end |=> busy)
    else $error("results dropped before the last rank");

  a_drain_end: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && $fell(busy) |-> $past(take && at_end))
    else $error("bank emptied without the last rank taken");

endmodule

// ===== hw/rtl/four_nearest_grid_points.sv =====
// A point passes the input, magnitude, square and sum registers into the sorted list;
//   rank 0 follows in the cycle after the last insert, then one rank per unstalled cycle.
// Throughput: one point per cycle while in_stall is low, set by the four-slot list insert;
//   a last point holds at the list while the previous four results are still being taken.
// Reset (synchronous): the list and result bank empty, radius returns to 1600000; a radius
//   write is registered in search_radius and then in the squared bound register.
module four_nearest_grid_points (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_wen,
  input  logic [fng_pkg::RAD_W-1:0]        cfg_wdata,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic signed [fng_pkg::POS_W-1:0] query_east,
  input  logic signed [fng_pkg::POS_W-1:0] query_north,
  input  logic signed [fng_pkg::POS_W-1:0] point_east,
  input  logic signed [fng_pkg::POS_W-1:0] point_north,
  input  fng_pkg::idx_t                    point_row,
  input  fng_pkg::idx_t                    point_col,
  input  logic                             last_point,
  output logic                             out_valid,
  input  logic                             out_stall,
  output fng_pkg::rank_t                   rank,
  output fng_pkg::idx_t                    near_row,
  output fng_pkg::idx_t                    near_col,
  output fng_pkg::dist_t                   near_dist_sq,
  output logic                             found,
  output logic                             last_result
);

  logic [fng_pkg::RAD_W-1:0] search_radius;
  logic                      adv;
  logic                      pt_valid;
  fng_pkg::point_t           pt;
  logic                      fire;
  logic                      snap_load;
  fng_pkg::snap_t            snap;
  logic                      load_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      search_radius <= fng_pkg::RADIUS_RESET;
    end else if (cfg_wen) begin
      search_radius <= cfg_wdata;
    end
  end

  // hold the whole pipe while an ending point waits for the result bank
  assign adv      = !(pt_valid && pt.last && !load_ready);
  assign in_stall = !adv;
  assign fire     = pt_valid && adv;

  fng_dist u_dist (
    .clk         (clk),
    .rst         (rst),
    .adv         (adv),
    .in_valid    (in_valid),
    .query_east  (query_east),
    .query_north (query_north),
    .point_east  (point_east),
    .point_north (point_north),
    .point_row   (point_row),
    .point_col   (point_col),
    .last_point  (last_point),
    .pt_valid    (pt_valid),
    .pt          (pt)
  );

  fng_list u_list (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .pt        (pt),
    .radius    (search_radius),
    .snap_load (snap_load),
    .snap      (snap)
  );

  fng_out u_out (
    .clk          (clk),
    .rst          (rst),
    .load         (snap_load),
    .snap         (snap),
    .load_ready   (load_ready),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .rank         (rank),
    .near_row     (near_row),
    .near_col     (near_col),
    .near_dist_sq (near_dist_sq),
    .found        (found),
    .last_result  (last_result)
  );

endmodule
